// ----- src/stepper_speed_ramp_step_period_defines.svh -----
// assertion macros for the stepper speed ramp block
// used by the top level only, no other dependencies
`ifndef STEPPER_SPEED_RAMP_STEP_PERIOD_DEFINES_SVH
`define STEPPER_SPEED_RAMP_STEP_PERIOD_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SSRSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SSRSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ssrsp_pkg.sv -----
// shared types and constants for the stepper speed ramp block
// no dependencies
`default_nettype none

package ssrsp_pkg;

  // field widths
  localparam int SPEED_W  = 16;
  localparam int COUNT_W  = 16;
  localparam int PERIOD_W = 20;
  localparam int CFG_IDX_W = 1;

  // default fraction bits of the speed format
  localparam int SPEED_FRAC_BITS_DEF = 8;

  // constants of the ramp and period maths
  localparam logic [PERIOD_W-1:0] US_PER_SEC   = 20'd1000000;
  localparam logic [SPEED_W-1:0]  RECIP5       = 16'd52429;  // ceil(2^18 / 5)
  localparam int                  RECIP5_SHIFT = 18;
  localparam logic [SPEED_W-1:0]  SPR_RESET    = 16'd200;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic ramp_mul;
    logic ramp_upd;
    logic sps_mul;
    logic div_init;
    logic div_step;
    logic load_out;
  } ssrsp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic moving;
  } ssrsp_sts_t;

endpackage

`default_nettype wire

// ----- src/ssrsp_ctrl.sv -----
// controller state machine for the stepper speed ramp block
// depends on ssrsp_pkg
`default_nettype none

module ssrsp_ctrl import ssrsp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire ssrsp_sts_t sts,
  output ssrsp_cmd_t      cmd
);

  localparam int CNT_W = $clog2(PERIOD_W + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RMUL  = 7'b0000010,
    S_RUPD  = 7'b0000100,
    S_SMUL  = 7'b0001000,
    S_DINIT = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } ssrsp_state_t;

  ssrsp_state_t     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_RMUL;
        end
      end
      S_RMUL: begin
        cmd.ramp_mul = 1'b1;
        state_nxt    = S_RUPD;
      end
      S_RUPD: begin
        cmd.ramp_upd = 1'b1;
        state_nxt    = S_SMUL;
      end
      S_SMUL: begin
        cmd.sps_mul = 1'b1;
        state_nxt   = sts.moving ? S_DINIT : S_DONE;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = CNT_W'(PERIOD_W);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/ssrsp_dp.sv -----
// datapath for the stepper speed ramp block: config, speed state,
// ramp multiply, steps-per-second multiply, radix-2 divider, output word
// depends on ssrsp_pkg
`default_nettype none

module ssrsp_dp import ssrsp_pkg::*; #(
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SPEED_W-1:0]   cfg_wdata,
  input  wire logic [COUNT_W-1:0]   in_step_count,
  input  wire ssrsp_cmd_t           cmd,
  output ssrsp_sts_t                sts,
  output logic [COUNT_W-1:0]        out_steps_moved,
  output logic                      out_moving,
  output logic [PERIOD_W-1:0]       out_step_period_us,
  output logic [SPEED_W-1:0]        out_speed_now
);

  localparam int PROD_W = 2 * SPEED_W;
  localparam int SPS_W  = PROD_W - SPEED_FRAC_BITS;
  localparam int Q5_W   = PROD_W - RECIP5_SHIFT;
  localparam logic [SPEED_W-1:0] QUARTER = SPEED_W'(1 << (SPEED_FRAC_BITS - 2));
  localparam logic [SPEED_W-1:0] HALF    = SPEED_W'(1 << (SPEED_FRAC_BITS - 1));

  logic [SPEED_W-1:0]  target_r, spr_r, speed_r;
  logic [COUNT_W-1:0]  count_r;
  logic                snap_r, neg_r;
  logic [Q5_W-1:0]     q5_r;
  logic [PROD_W-1:0]   sps_prod_r;
  logic [SPS_W-1:0]    den_r, rem_r;
  logic [PERIOD_W-1:0] quo_r;

  logic [SPEED_W:0]    gap;
  logic [SPEED_W-1:0]  mag;
  logic [SPEED_W-1:0]  step5;
  logic [SPEED_W-1:0]  speed_nxt;
  logic                moving;
  logic [SPS_W-1:0]    sps;
  logic [SPS_W:0]      trial;
  logic                take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      spr_r    <= SPR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_SPEED:  target_r <= cfg_wdata;
        REG_STEPS_PER_REV: spr_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // signed gap and its magnitude
  assign gap = {1'b0, target_r} - {1'b0, speed_r};
  assign mag = gap[SPEED_W] ? SPEED_W'(-gap) : gap[SPEED_W-1:0];

  // one fifth of the gap, truncated toward zero, from the reciprocal product
  assign step5 = SPEED_W'(q5_r);
  always_comb begin
    if (snap_r) begin
      speed_nxt = target_r;
    end else if (neg_r) begin
      speed_nxt = speed_r - step5;
    end else begin
      speed_nxt = speed_r + step5;
    end
  end

  assign moving     = (speed_r > HALF);
  assign sts.moving = moving;

  // steps per second, never below one
  assign sps = (sps_prod_r[PROD_W-1:SPEED_FRAC_BITS] == '0) ? SPS_W'(1)
                                                          : sps_prod_r[PROD_W-1:SPEED_FRAC_BITS];

  // restoring divider step
  assign trial = {rem_r, quo_r[PERIOD_W-1]};
  assign take  = (trial >= {1'b0, den_r});

  // speed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
    end else if (cmd.ramp_upd) begin
      speed_r <= speed_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      count_r <= in_step_count;
    end
    if (cmd.ramp_mul) begin
      snap_r <= (mag < QUARTER);
      neg_r  <= gap[SPEED_W];
      q5_r   <= Q5_W'((PROD_W'(mag) * PROD_W'(RECIP5)) >> RECIP5_SHIFT);
    end
    if (cmd.sps_mul) begin
      sps_prod_r <= speed_r * spr_r;
    end
    if (cmd.div_init) begin
      den_r <= sps;
      rem_r <= '0;
      quo_r <= US_PER_SEC;
    end else if (cmd.div_step) begin
      rem_r <= take ? SPS_W'(trial - {1'b0, den_r}) : trial[SPS_W-1:0];
      quo_r <= {quo_r[PERIOD_W-2:0], take};
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_steps_moved    <= moving ? count_r : '0;
      out_moving         <= moving;
      out_step_period_us <= moving ? quo_r : '0;
      out_speed_now      <= speed_r;
    end
  end

endmodule

`default_nettype wire

// ----- src/stepper_speed_ramp_step_period.sv -----
// top level of the stepper speed ramp block with step period
// depends on ssrsp_pkg, ssrsp_ctrl, ssrsp_dp and the assertion macro header
//
//   channel  ports                      direction  words
//   in       in_valid / in_ready        to block   step request
//   out      out_valid / out_ready      from block one result per request
//   cfg      cfg_we / cfg_index         to block   register write, no wait
//
// a batch runs ramp multiply, ramp update and steps-per-second multiply,
// then, if moving, the 20-step radix-2 divider for the period
// in_ready is high only while the controller is idle; a held result stalls
// the next batch at its last stage, not at acceptance
// rst_n is synchronous: speed clears, target to zero, steps per rev to 200
`default_nettype none
`include "stepper_speed_ramp_step_period_defines.svh"

module stepper_speed_ramp_step_period import ssrsp_pkg::*; #(
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SPEED_W-1:0]   cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [COUNT_W-1:0]   in_step_count,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [COUNT_W-1:0]        out_steps_moved,
  output logic                      out_moving,
  output logic [PERIOD_W-1:0]       out_step_period_us,
  output logic [SPEED_W-1:0]        out_speed_now
);

  localparam logic [SPEED_W-1:0] HALF = SPEED_W'(1 << (SPEED_FRAC_BITS - 1));

  ssrsp_cmd_t cmd;
  ssrsp_sts_t sts;

  // controller
  ssrsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  ssrsp_dp #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_step_count      (in_step_count),
    .cmd                (cmd),
    .sts                (sts),
    .out_steps_moved    (out_steps_moved),
    .out_moving         (out_moving),
    .out_step_period_us (out_step_period_us),
    .out_speed_now      (out_speed_now)
  );

  // checks
  `SSRSP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "block took a second word while busy")
  `SSRSP_ASSERT_NOW(a_stopped_zero, clk, rst_n, out_valid && !out_moving, out_step_period_us == '0 && out_steps_moved == '0, "stopped result carries steps or period")
  `SSRSP_ASSERT_NOW(a_moving_fast, clk, rst_n, out_valid && out_moving, out_speed_now > HALF, "moving result at or below half speed")

endmodule

`default_nettype wire
